// File: rtl/core/ratio_reduce_part_or_parts_defines.svh
// Assertion macros for the ratio reduction block.
`ifndef RATIO_REDUCE_PART_OR_PARTS_DEFINES_SVH
`define RATIO_REDUCE_PART_OR_PARTS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ratio reduce assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ratio reduce assertion failed");

`endif

// File: rtl/core/rrp_pkg.sv
// Types and constants shared by the ratio reduction block.
package rrp_pkg;

    localparam int OPERAND_WIDTH_DEF = 31;
    localparam int FIELD_W           = 31;

    typedef enum logic [1:0] {
        OUT_PART  = 2'd0,
        OUT_PARTS = 2'd1,
        OUT_RANGE = 2'd2,
        OUT_ORDER = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [FIELD_W-1:0] lesser;
        logic [FIELD_W-1:0] greater;
    } pair_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [FIELD_W-1:0] numerator;
        logic [FIELD_W-1:0] denominator;
    } ratio_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV_B,
        ST_DIV_A,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// File: rtl/core/rrp_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle on two nonzero operands.
module rrp_gcd
    import rrp_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    output unit_status_t status,
    output logic [W-1:0] result
);

    localparam int KW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [KW-1:0] k_reg, k_next;
    logic          finished;
    logic          x_ge_y;
    logic [W-1:0]  sub_hi, sub_lo, sub_diff;

    assign finished = busy_reg && ((x_reg == '0) || (y_reg == '0));
    assign x_ge_y   = (x_reg >= y_reg);
    assign sub_hi   = x_ge_y ? x_reg : y_reg;
    assign sub_lo   = x_ge_y ? y_reg : x_reg;
    assign sub_diff = sub_hi - sub_lo;

    always_comb
    begin
        busy_next = busy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = x;
            y_next    = y;
            k_next    = '0;
        end
        else if (finished)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_ge_y)
            begin
                x_next = sub_diff >> 1;
            end
            else
            begin
                y_next = sub_diff >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
    end

    assign status.busy = busy_reg;
    assign status.done = finished;
    assign result      = (x_reg | y_reg) << k_reg;

endmodule

// File: rtl/core/rrp_div.sv
// Restoring divider: one quotient bit per cycle, shared by both divisions.
module rrp_div
    import rrp_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output unit_status_t status,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic          finished;

    assign finished = busy_reg && (cnt_reg == '0);
    assign shifted  = {rem_reg, quo_reg[W-1]};
    assign trial    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (finished)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = finished;
    assign quotient    = quo_reg;

endmodule

// File: rtl/core/ratio_reduce_part_or_parts.sv
// Ratio reduction top level: sequencer over a binary gcd and a shared divider.
// Error items: IDLE goes straight to FINISH, which registers the result when the output is
// free and then returns to IDLE for the next item. Valid items pass through GCD, DIV_B
// (b/g) and DIV_A (a/g) on the way to FINISH, and the divisions run after the gcd ends.
// The next item is taken while a result waits in the output register.
// rst_n is asynchronous and clears the sequencer and output valid; no clearing pass.
module ratio_reduce_part_or_parts
    import rrp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pair_valid,
    output logic   pair_ready,
    input  pair_t  pair,
    output logic   ratio_valid,
    input  logic   ratio_ready,
    output ratio_t ratio
);

    localparam int W = OPERAND_WIDTH;

    state_t state_reg, state_next;

    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] g_reg, g_next;
    logic [W-1:0] m_reg, m_next;
    logic [W-1:0] n_reg, n_next;
    outcome_t     code_reg, code_next;
    ratio_t       ratio_reg, ratio_next;
    logic         ratio_valid_reg, ratio_valid_next;

    logic [W-1:0] in_b, in_a;
    logic         accept;
    logic         in_range_err, in_order_err;
    logic         out_free;

    logic         gcd_start;
    unit_status_t gcd_status;
    logic [W-1:0] gcd_result;
    logic         div_start;
    logic [W-1:0] div_dividend, div_divisor;
    unit_status_t div_status;
    logic [W-1:0] div_quotient;

    assign in_b         = pair.lesser[W-1:0];
    assign in_a         = pair.greater[W-1:0];
    assign accept       = pair_valid && pair_ready;
    assign in_range_err = (in_a <= W'(1)) || (in_b == '0);
    assign in_order_err = (in_b >= in_a);
    assign out_free     = !ratio_valid_reg || ratio_ready;

    rrp_gcd #(.W(W)) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .x      (in_a),
        .y      (in_b),
        .status (gcd_status),
        .result (gcd_result)
    );

    rrp_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_range_err || in_order_err) ? ST_FINISH : ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gcd_status.done)
                begin
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (div_status.done)
                begin
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pair_ready       = (state_reg == ST_IDLE);
        gcd_start        = 1'b0;
        div_start        = 1'b0;
        div_dividend     = b_reg;
        div_divisor      = gcd_result;
        b_next           = b_reg;
        a_next           = a_reg;
        g_next           = g_reg;
        m_next           = m_reg;
        n_next           = n_reg;
        code_next        = code_reg;
        ratio_next       = ratio_reg;
        ratio_valid_next = ratio_valid_reg && !ratio_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    b_next = in_b;
                    a_next = in_a;
                    m_next = '0;
                    n_next = '0;
                    if (in_range_err)
                    begin
                        code_next = OUT_RANGE;
                    end
                    else if (in_order_err)
                    begin
                        code_next = OUT_ORDER;
                    end
                    else
                    begin
                        gcd_start = 1'b1;
                    end
                end
            end
            ST_GCD:
            begin
                if (gcd_status.done)
                begin
                    g_next       = gcd_result;
                    code_next    = (gcd_result == b_reg) ? OUT_PART : OUT_PARTS;
                    div_start    = 1'b1;
                    div_dividend = b_reg;
                    div_divisor  = gcd_result;
                end
            end
            ST_DIV_B:
            begin
                if (div_status.done)
                begin
                    m_next       = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = a_reg;
                    div_divisor  = g_reg;
                end
            end
            ST_DIV_A:
            begin
                if (div_status.done)
                begin
                    n_next = div_quotient;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ratio_next.outcome     = code_reg;
                    ratio_next.numerator   = FIELD_W'(m_reg);
                    ratio_next.denominator = FIELD_W'(n_reg);
                    ratio_valid_next       = 1'b1;
                end
            end
            default:
            begin
                pair_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ratio_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ratio_valid_reg <= ratio_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        a_reg     <= a_next;
        g_reg     <= g_next;
        m_reg     <= m_next;
        n_reg     <= n_next;
        code_reg  <= code_next;
        ratio_reg <= ratio_next;
    end

    assign ratio_valid = ratio_valid_reg;
    assign ratio       = ratio_reg;

endmodule

// File: rtl/core/rrp_checker.sv
// Port-level checker for the ratio reduction block, bound to the top level.
`include "ratio_reduce_part_or_parts_defines.svh"

module rrp_checker
    import rrp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pair_valid,
    input logic   pair_ready,
    input pair_t  pair,
    input logic   ratio_valid,
    input logic   ratio_ready,
    input ratio_t ratio
);

    `RRP_ASSERT_NEXT(a_ratio_hold, ratio_valid && !ratio_ready, ratio_valid && $stable(ratio))
    `RRP_ASSERT_NEXT(a_busy_after_accept, pair_valid && pair_ready, !pair_ready)
    `RRP_ASSERT_NOW(a_error_zero, ratio_valid && (ratio.outcome == OUT_RANGE || ratio.outcome == OUT_ORDER), ratio.numerator == '0 && ratio.denominator == '0)
    `RRP_ASSERT_NOW(a_part_unit, ratio_valid && ratio.outcome == OUT_PART, ratio.numerator == FIELD_W'(1))

endmodule

bind ratio_reduce_part_or_parts rrp_checker u_rrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (pair_valid),
    .pair_ready  (pair_ready),
    .pair        (pair),
    .ratio_valid (ratio_valid),
    .ratio_ready (ratio_ready),
    .ratio       (ratio)
);
